[rtl/core/ppv_pkg.sv]
// Shared types and constants for the periodic polyhedron volume block.
`default_nettype none

package ppv_pkg;

  // Box length registers
  localparam int unsigned BOX_W = 15;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_Z = 2'd2;
  localparam logic [BOX_W-1:0] BOX_RESET = 15'd256;

  // Six-times-volume accumulator and the divide-by-six unit
  localparam int unsigned SUM_W = 64;
  localparam int unsigned DIV_DIGIT_W = 16;
  localparam int unsigned DIV_STEPS = SUM_W / DIV_DIGIT_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int unsigned REM_W = 3;
  localparam logic [REM_W:0] DIVISOR = 4'd6;

  // Partial dividend v < 2^19: floor(v / 6) = (v * RECIP) >> RECIP_SHIFT
  localparam int unsigned DIV_V_W = REM_W + DIV_DIGIT_W;
  localparam int unsigned RECIP_W = 20;
  localparam int unsigned RECIP_SHIFT = 22;
  localparam logic [RECIP_W-1:0] RECIP = 20'd699051;
  localparam int unsigned DPROD_W = DIV_V_W + RECIP_W;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;    // capture the accepted vertex
    logic wrap;       // wrap differences, latch reference and polygon state
    logic mul;        // cross product partial products
    logic sel_close;  // closing edge operands instead of the open edge
    logic dot;        // cross components times reference-to-centre
    logic acc;        // add or subtract the term
    logic div_load;   // start divide, clear the sum
    logic div_step;   // one 16-bit quotient digit of the divide
    logic out_load;   // signed quotient into the output register
  } ppv_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic poly_first;
    logic poly_last;
    logic cell_last;
    logic div_last;
  } ppv_sts_t;

endpackage

`default_nettype wire

[rtl/core/ppv_ctrl.sv]
// Sequencing state machine for the periodic polyhedron volume block.
`default_nettype none

module ppv_ctrl
  import ppv_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire ppv_sts_t sts_i,
  output ppv_cmd_t      cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_WRAP  = 8'b0000_0010,
    S_MUL   = 8'b0000_0100,
    S_DOT   = 8'b0000_1000,
    S_ACC   = 8'b0001_0000,
    S_DIVLD = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } ppv_state_e;

  ppv_state_e state_q, state_d;
  logic       close_q, close_d;
  logic       out_valid_q, out_valid_d;
  ppv_state_e done_state;

  // Where a vertex goes once its terms are in
  assign done_state = sts_i.cell_last ? S_DIVLD : S_IDLE;

  // Next state and commands
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    close_d = close_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = S_WRAP;
        end
      end
      S_WRAP: begin
        cmd_o.wrap = 1'b1;
        if (!sts_i.poly_first) begin
          close_d = 1'b0;
          state_d = S_MUL;
        end else if (sts_i.poly_last) begin
          close_d = 1'b1;
          state_d = S_MUL;
        end else begin
          state_d = done_state;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        cmd_o.sel_close = close_q;
        state_d = S_DOT;
      end
      S_DOT: begin
        cmd_o.dot = 1'b1;
        state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        if (!close_q && sts_i.poly_last) begin
          close_d = 1'b1;
          state_d = S_MUL;
        end else begin
          state_d = done_state;
        end
      end
      S_DIVLD: begin
        cmd_o.div_load = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      close_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      close_q     <= close_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[rtl/core/ppv_dp.sv]
// Datapath: minimum-image wrap, shared triple-product unit, sum and divide by six.
`default_nettype none

module ppv_dp
  import ppv_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire logic [BOX_W-1:0]             cfg_data_i,
  input  wire logic signed [COORD_BITS-1:0] vert_x_i,
  input  wire logic signed [COORD_BITS-1:0] vert_y_i,
  input  wire logic signed [COORD_BITS-1:0] vert_z_i,
  input  wire logic signed [COORD_BITS-1:0] ctr_x_i,
  input  wire logic signed [COORD_BITS-1:0] ctr_y_i,
  input  wire logic signed [COORD_BITS-1:0] ctr_z_i,
  input  wire logic                         forward_i,
  input  wire logic                         poly_first_i,
  input  wire logic                         poly_last_i,
  input  wire logic                         cell_last_i,
  input  wire ppv_cmd_t                     cmd_i,
  output ppv_sts_t                          sts_o,
  output logic signed [SUM_W-1:0]           volume_o
);

  localparam int unsigned DW = COORD_BITS + 1;               // wrapped difference
  localparam int unsigned PW = 2 * DW;                       // partial product
  localparam int unsigned CW = PW + 1;                       // cross component
  localparam int unsigned TW = CW + DW;                      // dot product lane
  localparam int unsigned WW = ((DW > BOX_W) ? DW : BOX_W) + 3; // wrap compare

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DW-1:0]         diff_t;

  // Single minimum-image correction of a difference
  function automatic diff_t wrap1(input diff_t d, input logic [BOX_W-1:0] len);
    logic signed [WW-1:0] d2;
    logic signed [WW-1:0] lw;
    diff_t                res;
    d2  = WW'(d) <<< 1;
    lw  = $signed(WW'({1'b0, len}));
    res = d;
    if (d2 > lw) begin
      res = d - DW'($signed({1'b0, len}));
    end else if (d2 < -lw) begin
      res = d + DW'($signed({1'b0, len}));
    end
    return res;
  endfunction

  // Box lengths
  logic [BOX_W-1:0] box_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q[0] <= BOX_RESET;
      box_q[1] <= BOX_RESET;
      box_q[2] <= BOX_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_BOX_X) box_q[0] <= cfg_data_i;
      if (cfg_idx_i == CFG_BOX_Y) box_q[1] <= cfg_data_i;
      if (cfg_idx_i == CFG_BOX_Z) box_q[2] <= cfg_data_i;
    end
  end

  // Captured transaction
  coord_t vert_q [3];
  coord_t ctr_q  [3];
  logic   fwd_q, pfirst_q, plast_q, clast_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      vert_q[0] <= vert_x_i;
      vert_q[1] <= vert_y_i;
      vert_q[2] <= vert_z_i;
      ctr_q[0]  <= ctr_x_i;
      ctr_q[1]  <= ctr_y_i;
      ctr_q[2]  <= ctr_z_i;
      fwd_q     <= forward_i;
      pfirst_q  <= poly_first_i;
      plast_q   <= poly_last_i;
      clast_q   <= cell_last_i;
    end
  end

  // Wrap stage: relative vertex and reference-to-centre
  coord_t ref_sel [3];
  diff_t  cur_d   [3];
  diff_t  rtc_d   [3];

  coord_t ref_q   [3];
  logic   need_ref_q;
  diff_t  rtc_q   [3];
  diff_t  first_q [3];
  diff_t  prev_q  [3];
  diff_t  cur_q   [3];

  always_comb begin
    for (int m = 0; m < 3; m++) begin
      ref_sel[m] = need_ref_q ? vert_q[m] : ref_q[m];
      cur_d[m]   = wrap1(DW'(vert_q[m]) - DW'(ctr_q[m]), box_q[m]);
      rtc_d[m]   = wrap1(DW'(ctr_q[m]) - DW'(ref_sel[m]), box_q[m]);
    end
  end

  // Triple-product operands: open edge prev->cur, closing edge cur->first
  diff_t op_a [3];
  diff_t op_b [3];

  always_comb begin
    for (int m = 0; m < 3; m++) begin
      op_a[m] = cmd_i.sel_close ? cur_q[m]   : prev_q[m];
      op_b[m] = cmd_i.sel_close ? first_q[m] : cur_q[m];
    end
  end

  logic signed [PW-1:0] prod_q [6];
  logic signed [CW-1:0] xprod  [3];
  logic signed [TW-1:0] dot_q  [3];
  logic signed [SUM_W-1:0] term;
  logic signed [SUM_W-1:0] sum_q;

  // Cross product components
  always_comb begin
    xprod[0] = CW'(prod_q[0]) - CW'(prod_q[1]);
    xprod[1] = CW'(prod_q[2]) - CW'(prod_q[3]);
    xprod[2] = CW'(prod_q[4]) - CW'(prod_q[5]);
    term = SUM_W'(dot_q[0]) + SUM_W'(dot_q[1]) + SUM_W'(dot_q[2]);
  end

  // Polygon state, products and the running sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      need_ref_q <= 1'b1;
      sum_q      <= '0;
      for (int m = 0; m < 3; m++) begin
        ref_q[m]   <= '0;
        rtc_q[m]   <= '0;
        first_q[m] <= '0;
        prev_q[m]  <= '0;
        cur_q[m]   <= '0;
      end
    end else begin
      if (cmd_i.wrap) begin
        need_ref_q <= 1'b0;
        for (int m = 0; m < 3; m++) begin
          ref_q[m] <= ref_sel[m];
          cur_q[m] <= cur_d[m];
          if (pfirst_q) begin
            rtc_q[m]   <= rtc_d[m];
            first_q[m] <= cur_d[m];
            prev_q[m]  <= cur_d[m];
          end
        end
      end
      // open edge consumes prev, so it moves on in the same cycle
      if (cmd_i.mul && !cmd_i.sel_close) begin
        for (int m = 0; m < 3; m++) begin
          prev_q[m] <= cur_q[m];
        end
      end
      if (cmd_i.acc) begin
        sum_q <= fwd_q ? (sum_q + term) : (sum_q - term);
      end else if (cmd_i.div_load) begin
        sum_q      <= '0;
        need_ref_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q[0] <= op_a[1] * op_b[2];
      prod_q[1] <= op_b[1] * op_a[2];
      prod_q[2] <= op_b[0] * op_a[2];
      prod_q[3] <= op_a[0] * op_b[2];
      prod_q[4] <= op_a[0] * op_b[1];
      prod_q[5] <= op_b[0] * op_a[1];
    end
    if (cmd_i.dot) begin
      for (int m = 0; m < 3; m++) begin
        dot_q[m] <= TW'(xprod[m]) * TW'(rtc_q[m]);
      end
    end
  end

  // Divide magnitude by six, one 16-bit quotient digit per cycle by reciprocal multiply
  logic [SUM_W-1:0]       div_q, div_d;
  logic [REM_W-1:0]       rem_q, rem_d;
  logic                   neg_q;
  logic [DIV_CNT_W-1:0]   cnt_q;
  logic [DIV_V_W-1:0]     dv;
  logic [DPROD_W-1:0]     dprod;
  logic [DIV_DIGIT_W-1:0] qdig;
  logic [DIV_V_W-1:0]     dres;

  always_comb begin
    dv    = {rem_q, div_q[SUM_W-1 -: DIV_DIGIT_W]};
    dprod = DPROD_W'(dv) * DPROD_W'(RECIP);
    qdig  = dprod[RECIP_SHIFT +: DIV_DIGIT_W];
    dres  = dv - DIV_V_W'(qdig) * DIV_V_W'(DIVISOR);
    rem_d = dres[REM_W-1:0];
    div_d = {div_q[SUM_W-DIV_DIGIT_W-1:0], qdig};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      div_q <= sum_q[SUM_W-1] ? (-sum_q) : sum_q;
      neg_q <= sum_q[SUM_W-1];
      rem_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_q <= div_d;
      rem_q <= rem_d;
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.out_load) begin
      volume_o <= neg_q ? (-$signed(div_q)) : $signed(div_q);
    end
  end

  assign sts_o.poly_first = pfirst_q;
  assign sts_o.poly_last  = plast_q;
  assign sts_o.cell_last  = clast_q;
  assign sts_o.div_last   = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

endmodule

`default_nettype wire

[rtl/core/periodic_polyhedron_volume.sv]
// Cell volume in a periodic box: each vertex transaction has accept and wrap steps,
// then a multiply, dot and accumulate step per triple product on one shared multiplier set.
// A vertex that ends a cell adds a sum load, four 16-bit divide-by-six
// digits, and the output load, which waits while the output register is full.
// Reset (rst_ni, asynchronous, active low) clears the sum, sets the reference
// point to be taken from the next vertex, and loads 256 into every box length.
`default_nettype none

module periodic_polyhedron_volume
  import ppv_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire logic [BOX_W-1:0]             cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic signed [COORD_BITS-1:0] vert_x_i,
  input  wire logic signed [COORD_BITS-1:0] vert_y_i,
  input  wire logic signed [COORD_BITS-1:0] vert_z_i,
  input  wire logic signed [COORD_BITS-1:0] ctr_x_i,
  input  wire logic signed [COORD_BITS-1:0] ctr_y_i,
  input  wire logic signed [COORD_BITS-1:0] ctr_z_i,
  input  wire logic                         forward_i,
  input  wire logic                         poly_first_i,
  input  wire logic                         poly_last_i,
  input  wire logic                         cell_last_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic signed [SUM_W-1:0]           volume_o
);

  ppv_cmd_t cmd;
  ppv_sts_t sts;

  ppv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ppv_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .vert_x_i     (vert_x_i),
    .vert_y_i     (vert_y_i),
    .vert_z_i     (vert_z_i),
    .ctr_x_i      (ctr_x_i),
    .ctr_y_i      (ctr_y_i),
    .ctr_z_i      (ctr_z_i),
    .forward_i    (forward_i),
    .poly_first_i (poly_first_i),
    .poly_last_i  (poly_last_i),
    .cell_last_i  (cell_last_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .volume_o     (volume_o)
  );

  // A transaction always occupies the block for at least the wrap cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again right after a transaction");

  // A new result only appears after the output load cycle, which is busy
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a finished cell");

  // A polygon start that neither closes nor ends the cell has no term to add
  a_open_start_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && poly_first_i && !poly_last_i && !cell_last_i
    |=> ##1 in_ready_o)
    else $error("polygon start took more than the wrap cycle");

endmodule

`default_nettype wire

[tb/periodic_polyhedron_volume_test.sv]
// Self-checking testbench for the periodic polyhedron volume block.
module periodic_polyhedron_volume_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ppv_pkg::*;

  localparam int COORD_W = 16;
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT = 600000;

  // One vertex transaction as presented on the input channel
  typedef struct packed {
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
    logic signed [COORD_W-1:0] vz;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic                      fwd;
    logic                      pfirst;
    logic                      plast;
    logic                      clast;
  } vertex_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_idx_i = '0;
  logic [BOX_W-1:0]          cfg_data_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic signed [COORD_W-1:0] vert_x_i = '0;
  logic signed [COORD_W-1:0] vert_y_i = '0;
  logic signed [COORD_W-1:0] vert_z_i = '0;
  logic signed [COORD_W-1:0] ctr_x_i = '0;
  logic signed [COORD_W-1:0] ctr_y_i = '0;
  logic signed [COORD_W-1:0] ctr_z_i = '0;
  logic                      forward_i = 1'b0;
  logic                      poly_first_i = 1'b0;
  logic                      poly_last_i = 1'b0;
  logic                      cell_last_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic signed [SUM_W-1:0]   volume_o;

  periodic_polyhedron_volume #(
    .COORD_BITS (COORD_W)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .vert_x_i     (vert_x_i),
    .vert_y_i     (vert_y_i),
    .vert_z_i     (vert_z_i),
    .ctr_x_i      (ctr_x_i),
    .ctr_y_i      (ctr_y_i),
    .ctr_z_i      (ctr_z_i),
    .forward_i    (forward_i),
    .poly_first_i (poly_first_i),
    .poly_last_i  (poly_last_i),
    .cell_last_i  (cell_last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .volume_o     (volume_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Vertices waiting to be sent, and cell volumes waiting to come out
  vertex_t vertex_backlog[$];
  longint  volume_expected[$];
  int      queued = 0;
  int      errors = 0;
  int      cycle_count = 0;

  // Predictor state: box shadow, reference point, polygon vectors, 6*volume sum
  longint      box_len[3] = '{256, 256, 256};
  longint      anchor[3] = '{0, 0, 0};
  bit          anchor_pending = 1'b1;
  longint      hub_ofs[3] = '{0, 0, 0};
  longint      lead_spoke[3] = '{0, 0, 0};
  longint      last_spoke[3] = '{0, 0, 0};
  logic [63:0] vol6_acc = '0;

  // Single minimum-image fold of one difference
  function automatic longint min_image(longint d, longint len);
    if (2 * d > len) return d - len;
    if (2 * d < -len) return d + len;
    return d;
  endfunction

  // hub . (a x b) for one edge
  function automatic longint edge_term(longint a0, longint a1, longint a2,
                                       longint b0, longint b1, longint b2);
    longint x, y, z;
    x = a1 * b2 - b1 * a2;
    y = b0 * a2 - a0 * b2;
    z = a0 * b1 - b0 * a1;
    return hub_ofs[0] * x + hub_ofs[1] * y + hub_ofs[2] * z;
  endfunction

  function automatic void add_term(longint t, logic fwd);
    if (fwd) vol6_acc = vol6_acc + t;
    else vol6_acc = vol6_acc - t;
  endfunction

  // Advance the predictor by one accepted vertex; queue a volume at cell end
  function automatic void track_vertex(vertex_t it);
    longint v[3];
    longint c[3];
    longint cur[3];
    longint vol;
    int m;
    v[0] = it.vx;
    v[1] = it.vy;
    v[2] = it.vz;
    c[0] = it.cx;
    c[1] = it.cy;
    c[2] = it.cz;
    if (anchor_pending) begin
      for (m = 0; m < 3; m++) anchor[m] = v[m];
      anchor_pending = 1'b0;
    end
    for (m = 0; m < 3; m++) cur[m] = min_image(v[m] - c[m], box_len[m]);
    if (it.pfirst) begin
      for (m = 0; m < 3; m++) begin
        hub_ofs[m] = min_image(c[m] - anchor[m], box_len[m]);
        lead_spoke[m] = cur[m];
      end
    end else begin
      add_term(edge_term(last_spoke[0], last_spoke[1], last_spoke[2],
                         cur[0], cur[1], cur[2]), it.fwd);
    end
    // closing edge back to the polygon's first vertex
    if (it.plast) begin
      add_term(edge_term(cur[0], cur[1], cur[2],
                         lead_spoke[0], lead_spoke[1], lead_spoke[2]), it.fwd);
    end
    for (m = 0; m < 3; m++) last_spoke[m] = cur[m];
    if (it.clast) begin
      vol = vol6_acc;
      volume_expected = {volume_expected, vol / 6};
      vol6_acc = '0;
      anchor_pending = 1'b1;
    end
  endfunction

  task automatic push_vtx(logic signed [COORD_W-1:0] vx, logic signed [COORD_W-1:0] vy,
                          logic signed [COORD_W-1:0] vz, logic signed [COORD_W-1:0] cx,
                          logic signed [COORD_W-1:0] cy, logic signed [COORD_W-1:0] cz,
                          logic fwd, logic pf, logic pl, logic cl);
    vertex_t it;
    it = '{vx, vy, vz, cx, cy, cz, fwd, pf, pl, cl};
    vertex_backlog = {vertex_backlog, it};
    queued++;
  endtask

  // Point within +/- span of a given one; a huge span means any coordinate
  function automatic logic signed [COORD_W-1:0] near(logic signed [COORD_W-1:0] at,
                                                      int span);
    int offs;
    if (span > 32767) return COORD_W'($urandom);
    offs = $urandom_range(0, 2 * span);
    offs = offs - span;
    return at + offs[COORD_W-1:0];
  endfunction

  // Well-formed cell with random geometry, a few vertices carrying broken flags
  task automatic queue_cell(int span);
    logic signed [COORD_W-1:0] bx, by, bz, cx, cy, cz;
    int npoly, nvert, p, k;
    logic fwd, pf, pl, cl;
    bx = COORD_W'($urandom);
    by = COORD_W'($urandom);
    bz = COORD_W'($urandom);
    npoly = $urandom_range(1, 6);
    for (p = 0; p < npoly; p++) begin
      cx = near(bx, span);
      cy = near(by, span);
      cz = near(bz, span);
      fwd = 1'($urandom_range(0, 1));
      nvert = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 6);
      for (k = 0; k < nvert; k++) begin
        pf = (k == 0);
        pl = (k == nvert - 1);
        cl = pl && (p == npoly - 1);
        if ($urandom_range(0, 24) == 0) {pf, pl, cl} = 3'($urandom);
        push_vtx(near(cx, span), near(cy, span), near(cz, span), cx, cy, cz,
                 fwd, pf, pl, cl);
      end
    end
  endtask

  // Short run of fully random vertices and flags
  task automatic queue_noise();
    int n, k;
    n = $urandom_range(1, 4);
    for (k = 0; k < n; k++) begin
      push_vtx(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
               COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
               1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  task automatic run_random(int n);
    int target;
    target = queued + n;
    while (queued < target) begin
      if ($urandom_range(0, 11) == 0) begin
        queue_noise();
      end else begin
        case ($urandom_range(0, 3))
          0: queue_cell(48);
          1: queue_cell(400);
          2: queue_cell(6000);
          default: queue_cell(65536);
        endcase
      end
    end
  endtask

  // Hold until all vertices are sent and every volume is back, then let it settle
  task automatic drain();
    while (vertex_backlog.size() != 0 || in_valid_i || volume_expected.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Box length writes on consecutive cycles; only called while idle
  task automatic write_boxes(logic [BOX_W-1:0] lx, logic [BOX_W-1:0] ly,
                             logic [BOX_W-1:0] lz);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_BOX_X;
    cfg_data_i <= lx;
    box_len[CFG_BOX_X] = lx;
    @(posedge clk_i);
    cfg_idx_i <= CFG_BOX_Y;
    cfg_data_i <= ly;
    box_len[CFG_BOX_Y] = ly;
    @(posedge clk_i);
    cfg_idx_i <= CFG_BOX_Z;
    cfg_data_i <= lz;
    box_len[CFG_BOX_Z] = lz;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Input driver: bursts of transactions with random gaps
  vertex_t on_wire;
  int      burst_left = 1;
  int      gap_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) track_vertex(on_wire);
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (vertex_backlog.size() == 0) begin
          in_valid_i <= 1'b0;
        end else begin
          on_wire = vertex_backlog.pop_front();
          vert_x_i <= on_wire.vx;
          vert_y_i <= on_wire.vy;
          vert_z_i <= on_wire.vz;
          ctr_x_i <= on_wire.cx;
          ctr_y_i <= on_wire.cy;
          ctr_z_i <= on_wire.cz;
          forward_i <= on_wire.fwd;
          poly_first_i <= on_wire.pfirst;
          poly_last_i <= on_wire.plast;
          cell_last_i <= on_wire.clast;
          in_valid_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Output back-pressure: modes from always ready to long stalls
  int stall_mode = 0;
  int mode_left = 0;
  int stall_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 300);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom);
        2: out_ready_i <= ($urandom_range(0, 7) == 0);
        default: begin
          if (stall_left != 0) begin
            stall_left--;
            out_ready_i <= 1'b0;
          end else begin
            out_ready_i <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 40);
          end
        end
      endcase
    end
  end

  // Output monitor: each volume transaction against the oldest prediction
  longint vol_want;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (volume_expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected volume, expected none, actual %0d", $time, volume_o);
      end else begin
        vol_want = volume_expected.pop_front();
        if (volume_o !== vol_want) begin
          errors++;
          $display("%0t: volume mismatch, expected %0d, actual %0d",
                   $time, vol_want, volume_o);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // single-vertex polygon closing the cell: zero volume
    push_vtx(16'sd10, 16'sd20, 16'sd30, 16'sd5, 16'sd5, 16'sd5, 1'b1, 1'b1, 1'b1, 1'b1);
    // forward triangle then reversed triangle
    push_vtx(16'sd0, 16'sd0, 16'sd0, 16'sd85, 16'sd85, 16'sd0, 1'b1, 1'b1, 1'b0, 1'b0);
    push_vtx(16'sd256, 16'sd0, 16'sd0, 16'sd85, 16'sd85, 16'sd0, 1'b1, 1'b0, 1'b0, 1'b0);
    push_vtx(16'sd0, 16'sd256, 16'sd0, 16'sd85, 16'sd85, 16'sd0, 1'b1, 1'b0, 1'b1, 1'b0);
    push_vtx(16'sd0, 16'sd0, 16'sd0, 16'sd85, 16'sd0, 16'sd85, 1'b0, 1'b1, 1'b0, 1'b0);
    push_vtx(16'sd256, 16'sd0, 16'sd0, 16'sd85, 16'sd0, 16'sd85, 1'b0, 1'b0, 1'b0, 1'b0);
    push_vtx(16'sd0, 16'sd0, 16'sd256, 16'sd85, 16'sd0, 16'sd85, 1'b0, 1'b0, 1'b1, 1'b1);
    // coordinate extremes, far beyond one and a half boxes
    push_vtx(16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000,
             1'b1, 1'b1, 1'b0, 1'b0);
    push_vtx(-16'sh8000, 16'sh7fff, 16'sd0, -16'sh8000, 16'sh7fff, -16'sh8000,
             1'b1, 1'b0, 1'b0, 1'b0);
    push_vtx(16'sd0, -16'sd1, -16'sh8000, -16'sh8000, 16'sh7fff, -16'sh8000,
             1'b1, 1'b0, 1'b1, 1'b0);
    // vertices after a closed polygon with no new polygon start
    push_vtx(16'sd100, -16'sd100, 16'sh7fff, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0, 1'b0);
    push_vtx(-16'sd1, -16'sd1, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b1, 1'b1);
    // cell ends while its polygon is still open
    push_vtx(16'sd1, 16'sd2, 16'sd3, 16'sd200, -16'sd200, 16'sd100, 1'b1, 1'b1, 1'b0, 1'b0);
    push_vtx(16'sd300, 16'sd400, -16'sd500, 16'sd200, -16'sd200, 16'sd100,
             1'b1, 1'b0, 1'b0, 1'b0);
    push_vtx(-16'sd128, 16'sd127, 16'sd128, 16'sd200, -16'sd200, 16'sd100,
             1'b1, 1'b0, 1'b0, 1'b1);
    // differences exactly at and just past half a box
    push_vtx(16'sd128, -16'sd128, 16'sd129, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1, 1'b0, 1'b0);
    push_vtx(-16'sd129, 16'sd128, -16'sd128, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0, 1'b0, 1'b0);
    push_vtx(16'sd127, 16'sd0, -16'sd127, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0, 1'b1, 1'b1);

    run_random(150);
    drain();

    write_boxes(15'd32767, 15'd32767, 15'd32767);
    run_random(230);
    drain();

    write_boxes(15'd1, 15'd1, 15'd1);
    run_random(200);
    drain();

    // zero box length: no folding at all
    write_boxes(15'd0, 15'd0, 15'd0);
    run_random(120);
    drain();

    write_boxes(15'($urandom_range(1, 32767)), 15'($urandom_range(1, 32767)),
                15'($urandom_range(1, 32767)));
    run_random(200);
    drain();

    write_boxes(15'd32767, 15'd1, 15'd700);
    run_random(200);
    drain();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
